@@ rtl/ile_pkg.sv @@
package ile_pkg;

  localparam int DataW       = 32;
  localparam int PosW        = 9;
  localparam int FuncW       = 3;
  localparam int StatW       = 2;
  localparam int DefCapacity = 256;

  localparam logic [FuncW-1:0] OP_READ   = 3'd0;
  localparam logic [FuncW-1:0] OP_FRONT  = 3'd1;
  localparam logic [FuncW-1:0] OP_BACK   = 3'd2;
  localparam logic [FuncW-1:0] OP_AT     = 3'd3;
  localparam logic [FuncW-1:0] OP_DELETE = 3'd4;

  localparam logic [StatW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_DRAIN,
    S_INSWR,
    S_FINISH
  } ile_state_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [PosW-1:0]         element_count;
    logic [StatW-1:0]        status;
  } ile_rsp_t;

endpackage

@@ rtl/ile_ifs.sv @@
interface ile_req_if;
  import ile_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FuncW-1:0]        func;
  logic [PosW-1:0]         position;
  logic signed [DataW-1:0] item_value;

  modport source (output valid, output func, output position, output item_value,
                  input ready);
  modport sink (input valid, input func, input position, input item_value,
                output ready);
endinterface

interface ile_rsp_if;
  import ile_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] read_value;
  logic [PosW-1:0]         element_count;
  logic [StatW-1:0]        status;

  modport source (output valid, output read_value, output element_count,
                  output status, input ready);
  modport sink (input valid, input read_value, input element_count, input status,
                output ready);
endinterface

@@ rtl/ile_store.sv @@
module ile_store #(
  parameter int CAPACITY = ile_pkg::DefCapacity,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ile_pkg::DataW-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [ile_pkg::DataW-1:0] rdata
);
  import ile_pkg::*;

  logic [DataW-1:0] mem [CAPACITY];
  logic [DataW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ile_ctrl.sv @@
module ile_ctrl #(
  parameter int CAPACITY = ile_pkg::DefCapacity,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [ile_pkg::FuncW-1:0] req_func,
  input  logic [ile_pkg::PosW-1:0]  req_position,
  input  logic [ile_pkg::DataW-1:0] req_value,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ile_pkg::ile_rsp_t         res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [ile_pkg::DataW-1:0] mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  logic [ile_pkg::DataW-1:0] mem_rdata
);
  import ile_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > PosW) ? CW : PosW;

  ile_state_t state_r, state_nxt;

  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    end_r, end_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic             ins_r, ins_nxt;
  logic [DataW-1:0] val_r, val_nxt;
  logic             wb_vld_r, wb_vld_nxt;
  logic [AW-1:0]    wb_addr_r, wb_addr_nxt;
  logic [DataW-1:0] res_rd_r, res_rd_nxt;
  logic [StatW-1:0] res_st_r, res_st_nxt;

  logic            accept;
  logic [CMPW-1:0] pos_ext, cnt_ext, tgt_ext;
  logic            is_rd, is_ins, is_del;
  logic            rd_ok, ins_rng, ins_full, ins_ok, del_ok;

  assign accept  = req_valid && (state_r == S_IDLE);
  assign pos_ext = CMPW'(req_position);
  assign cnt_ext = CMPW'(count_r);

  always_comb begin
    is_rd  = (req_func == OP_READ);
    is_del = (req_func == OP_DELETE);
    is_ins = 1'b0;
    tgt_ext = pos_ext;
    case (req_func)
      OP_FRONT: begin
        is_ins  = 1'b1;
        tgt_ext = '0;
      end
      OP_BACK: begin
        is_ins  = 1'b1;
        tgt_ext = cnt_ext;
      end
      OP_AT: begin
        is_ins  = 1'b1;
      end
      default: ;
    endcase
    rd_ok    = pos_ext < cnt_ext;
    del_ok   = pos_ext < cnt_ext;
    ins_rng  = tgt_ext > cnt_ext;
    ins_full = cnt_ext >= CMPW'(CAPACITY);
    ins_ok   = !ins_rng && !ins_full;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_rd && rd_ok) begin
            state_nxt = S_READ;
          end else if (is_ins && ins_ok) begin
            state_nxt = (tgt_ext == cnt_ext) ? S_INSWR : S_SHIFT;
          end else if (is_del && del_ok) begin
            state_nxt = (pos_ext + CMPW'(1) == cnt_ext) ? S_FINISH : S_SHIFT;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_READ:   state_nxt = S_FINISH;
      S_SHIFT:  state_nxt = (idx_r == end_r) ? S_DRAIN : S_SHIFT;
      S_DRAIN:  state_nxt = ins_r ? S_INSWR : S_FINISH;
      S_INSWR:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = res_ready ? S_IDLE : S_FINISH;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    end_nxt     = end_r;
    pos_nxt     = pos_r;
    ins_nxt     = ins_r;
    val_nxt     = val_r;
    res_rd_nxt  = res_rd_r;
    res_st_nxt  = res_st_r;
    wb_vld_nxt  = 1'b0;
    wb_addr_nxt = wb_addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_rd_nxt = '0;
          res_st_nxt = ST_DONE;
          ins_nxt    = is_ins;
          val_nxt    = req_value;
          if (is_rd) begin
            if (!rd_ok) begin
              res_rd_nxt = '1;
              res_st_nxt = ST_RANGE;
            end
          end else if (is_ins) begin
            if (ins_rng) begin
              res_st_nxt = ST_RANGE;
            end else if (ins_full) begin
              res_st_nxt = ST_FULL;
            end else begin
              idx_nxt   = AW'(cnt_ext - CMPW'(1));
              end_nxt   = AW'(tgt_ext);
              pos_nxt   = AW'(tgt_ext);
              count_nxt = count_r + CW'(1);
            end
          end else if (is_del) begin
            if (del_ok) begin
              idx_nxt   = AW'(pos_ext + CMPW'(1));
              end_nxt   = AW'(cnt_ext - CMPW'(1));
              count_nxt = count_r - CW'(1);
            end else begin
              res_st_nxt = ST_RANGE;
            end
          end else begin
            res_st_nxt = ST_RANGE;
          end
        end
      end
      S_READ: begin
        res_rd_nxt = mem_rdata;
      end
      S_SHIFT: begin
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = ins_r ? (idx_r + AW'(1)) : (idx_r - AW'(1));
        idx_nxt     = ins_r ? (idx_r - AW'(1)) : (idx_r + AW'(1));
      end
      default: ;
    endcase
  end

  always_comb begin
    req_ready = (state_r == S_IDLE);
    res_valid = (state_r == S_FINISH);
    mem_raddr = (state_r == S_IDLE) ? AW'(pos_ext) : idx_r;
    mem_we    = wb_vld_r || (state_r == S_INSWR);
    mem_waddr = wb_vld_r ? wb_addr_r : pos_r;
    mem_wdata = wb_vld_r ? mem_rdata : val_r;
  end

  always_comb begin
    logic [CMPW-1:0] cnt_out;
    cnt_out           = CMPW'(count_r);
    res.read_value    = res_rd_r;
    res.element_count = cnt_out[PosW-1:0];
    res.status        = res_st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      wb_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      wb_vld_r <= wb_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    end_r     <= end_nxt;
    pos_r     <= pos_nxt;
    ins_r     <= ins_nxt;
    val_r     <= val_nxt;
    wb_addr_r <= wb_addr_nxt;
    res_rd_r  <= res_rd_nxt;
    res_st_r  <= res_st_nxt;
  end

endmodule

@@ rtl/indexed_list_engine.sv @@
// Indexed list engine: an ordered store of up to CAPACITY signed 32-bit values.
// in_ch carries one request per transaction (func, position, item_value): read
// at an index, insert at front, back or before an index, or delete at an index.
// out_ch returns one transaction per request: read_value, element_count, status.
// The values live in a single-port-write, single-port-read memory; inserts and
// deletes move the tail one entry per cycle through a read/write-back pipe.
// Steps per request: a read in range reads the memory and then finishes; an
// append writes the new value straight away; an insert with shift moves the
// tail up from the last entry down to the position, then writes the new value;
// a delete moves the tail down from position + 1, except for the last element;
// refused or out-of-range requests finish without touching the memory.
// The result sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, a second finished result waits inside until
// the output register frees, and no further request is accepted meanwhile.
// Reset (rst_n low, synchronous) empties the list; memory contents are not
// cleared since only entries below the count are ever read.
module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::DefCapacity
) (
  input logic      clk,
  input logic      rst_n,
  ile_req_if.sink  in_ch,
  ile_rsp_if.source out_ch
);
  import ile_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [DataW-1:0] mem_rdata;

  logic     res_valid;
  logic     res_ready;
  ile_rsp_t res;

  logic     out_valid_r, out_valid_nxt;
  ile_rsp_t out_r;

  ile_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_ch.valid),
    .req_ready    (in_ch.ready),
    .req_func     (in_ch.func),
    .req_position (in_ch.position),
    .req_value    (in_ch.item_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  ile_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_value    = out_r.read_value;
  assign out_ch.element_count = out_r.element_count;
  assign out_ch.status        = out_r.status;

endmodule
